[sv/pol_pkg.sv]
`timescale 1ns / 1ps

package pol_pkg;

	localparam int CAPACITY = 16;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	localparam int ACT_W = 3;
	localparam int VAL_W = 32;
	localparam int POS_W = 16;
	localparam int ST_W = 3;
	localparam int IDX_W = 4;
	localparam int LEN_W = 5;

	localparam logic [ACT_W-1:0] ACT_APPEND = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PREPEND = 3'd1;
	localparam logic [ACT_W-1:0] ACT_INSERT = 3'd2;
	localparam logic [ACT_W-1:0] ACT_DEL_LAST = 3'd3;
	localparam logic [ACT_W-1:0] ACT_DEL_FIRST = 3'd4;
	localparam logic [ACT_W-1:0] ACT_DEL_POS = 3'd5;
	localparam logic [ACT_W-1:0] ACT_DUMP = 3'd6;

	localparam logic [ST_W-1:0] ST_OK = 3'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 3'd1;
	localparam logic [ST_W-1:0] ST_INVALID = 3'd2;
	localparam logic [ST_W-1:0] ST_BOUNDS = 3'd3;
	localparam logic [ST_W-1:0] ST_FULL = 3'd4;

endpackage

[sv/pol_if.sv]
`timescale 1ns / 1ps

interface pol_req_if;
	logic valid;
	logic ready;
	logic [pol_pkg::ACT_W-1:0] action;
	logic signed [pol_pkg::VAL_W-1:0] value;
	logic signed [pol_pkg::POS_W-1:0] position;

	modport source(output valid, action, value, position, input ready);
	modport sink(input valid, action, value, position, output ready);
endinterface

interface pol_rsp_if;
	logic valid;
	logic ready;
	logic [pol_pkg::ST_W-1:0] status;
	logic signed [pol_pkg::VAL_W-1:0] element;
	logic [pol_pkg::IDX_W-1:0] element_index;
	logic [pol_pkg::LEN_W-1:0] length;
	logic last;

	modport source(output valid, status, element, element_index, length, last, input ready);
	modport sink(input valid, status, element, element_index, length, last, output ready);
endinterface

[sv/positional_ordered_list.sv]
`timescale 1ns / 1ps
// from acceptance to result: a rejected action goes straight to the result; a delete moves the
// entries behind it down, an insert moves those from its point up and then writes its value (one
// entry moved per cycle through the memory port); a dump reads and then outputs each element
// one item at a time: the next item is taken the cycle after the final result is loaded, even
// while it waits; a stalled result holds the block until the output register frees up
// reset: occupancy and control clear at once, entries keep no reset and are never read unwritten
module positional_ordered_list (
	input logic clk,
	input logic arst_n,
	pol_req_if.sink req,
	pol_rsp_if.source rsp
);
	import pol_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SHIFT = 3'd1;
	localparam logic [2:0] S_PUT = 3'd2;
	localparam logic [2:0] S_RESP = 3'd3;
	localparam logic [2:0] S_DRD = 3'd4;
	localparam logic [2:0] S_DWR = 3'd5;

	logic [2:0] state_q;
	logic [CW-1:0] occ_q;
	logic [CW-1:0] mv_q;
	logic [AW-1:0] rd_q;
	logic [AW-1:0] wdst_q;
	logic [AW-1:0] idx_q;
	logic pend_q;
	logic up_q;
	logic [ST_W-1:0] st_q;
	logic [VAL_W-1:0] val_q;

	logic [VAL_W-1:0] mem [CAPACITY];
	logic [VAL_W-1:0] rdata_q;
	logic we;
	logic re;
	logic [AW-1:0] wa;
	logic [AW-1:0] ra;
	logic [VAL_W-1:0] wd;

	logic o_valid_q;
	logic [ST_W-1:0] o_status_q;
	logic [VAL_W-1:0] o_elem_q;
	logic [IDX_W-1:0] o_idx_q;
	logic [LEN_W-1:0] o_len_q;
	logic o_last_q;
	logic o_free;
	logic o_load;

	logic acc;
	logic [2:0] d_state;
	logic [ST_W-1:0] d_status;
	logic [AW-1:0] d_idx;
	logic [CW-1:0] d_mv;
	logic [AW-1:0] d_rd;
	logic d_up;
	logic d_full;
	logic d_empty;
	logic p_neg;
	logic p_le1;
	logic [POS_W-2:0] p_mag;
	logic [POS_W-2:0] n_ext;
	logic [AW-1:0] p_idx;
	logic dump_end;

	assign acc = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign o_free = !o_valid_q || rsp.ready;
	assign o_load = o_free && ((state_q == S_RESP) || (state_q == S_DWR));

	assign d_full = (occ_q >= CW'(CAPACITY));
	assign d_empty = (occ_q == '0);
	assign p_neg = req.position[POS_W-1];
	assign p_mag = req.position[POS_W-2:0];
	assign p_le1 = (p_mag <= (POS_W-1)'(1));
	assign n_ext = (POS_W-1)'(occ_q);
	assign p_idx = AW'(p_mag - (POS_W-1)'(1));

	always_comb begin
		d_state = S_RESP;
		d_status = ST_OK;
		d_idx = '0;
		d_mv = '0;
		d_rd = '0;
		d_up = 1'b1;
		unique case (req.action)
			ACT_APPEND, ACT_PREPEND, ACT_INSERT: begin
				if (req.action == ACT_INSERT && p_neg) begin
					d_status = ST_INVALID;
				end else if (d_full) begin
					d_status = ST_FULL;
				end else if (req.action == ACT_APPEND) begin
					d_state = S_SHIFT;
					d_idx = AW'(occ_q);
				end else if (req.action == ACT_PREPEND || d_empty || p_le1) begin
					d_state = S_SHIFT;
					d_idx = '0;
				end else if (p_mag > n_ext + (POS_W-1)'(1)) begin
					d_status = ST_BOUNDS;
				end else begin
					d_state = S_SHIFT;
					d_idx = p_idx;
				end
				d_mv = occ_q - CW'(d_idx);
				d_rd = AW'(occ_q - CW'(1));
			end
			ACT_DEL_LAST, ACT_DEL_FIRST, ACT_DEL_POS: begin
				d_up = 1'b0;
				if (d_empty) begin
					d_status = ST_EMPTY;
				end else if (req.action == ACT_DEL_LAST) begin
					d_state = S_SHIFT;
					d_idx = AW'(occ_q - CW'(1));
				end else if (req.action == ACT_DEL_FIRST) begin
					d_state = S_SHIFT;
					d_idx = '0;
				end else if (p_neg) begin
					d_status = ST_INVALID;
				end else if (p_le1) begin
					d_state = S_SHIFT;
					d_idx = '0;
				end else if (p_mag > n_ext) begin
					d_status = ST_BOUNDS;
				end else begin
					d_state = S_SHIFT;
					d_idx = p_idx;
				end
				d_mv = occ_q - CW'(1) - CW'(d_idx);
				d_rd = d_idx + AW'(1);
			end
			ACT_DUMP: begin
				if (d_empty) begin
					d_status = ST_EMPTY;
				end else begin
					d_state = S_DRD;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		we = 1'b0;
		re = 1'b0;
		wa = wdst_q;
		wd = rdata_q;
		ra = rd_q;
		unique case (state_q)
			S_SHIFT: begin
				we = pend_q;
				re = (mv_q != '0);
			end
			S_PUT: begin
				we = 1'b1;
				wa = idx_q;
				wd = val_q;
			end
			S_DRD: re = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rdata_q <= mem[ra];
		end
	end

	assign dump_end = (CW'(rd_q) + CW'(1) == occ_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q <= '0;
			pend_q <= 1'b0;
			o_valid_q <= 1'b0;
		end else begin
			if (o_load) begin
				o_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				o_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						state_q <= d_state;
						st_q <= d_status;
						idx_q <= d_idx;
						mv_q <= d_mv;
						rd_q <= (req.action == ACT_DUMP) ? '0 : d_rd;
						up_q <= d_up;
						val_q <= req.value;
						pend_q <= 1'b0;
					end
				end
				S_SHIFT: begin
					if (re) begin
						pend_q <= 1'b1;
						wdst_q <= up_q ? rd_q + AW'(1) : rd_q - AW'(1);
						rd_q <= up_q ? rd_q - AW'(1) : rd_q + AW'(1);
						mv_q <= mv_q - CW'(1);
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							if (up_q) begin
								state_q <= S_PUT;
							end else begin
								occ_q <= occ_q - CW'(1);
								state_q <= S_RESP;
							end
						end
					end
				end
				S_PUT: begin
					occ_q <= occ_q + CW'(1);
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (o_free) begin
						o_status_q <= st_q;
						o_elem_q <= '0;
						o_idx_q <= '0;
						o_len_q <= LEN_W'(occ_q);
						o_last_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DRD: state_q <= S_DWR;
				S_DWR: begin
					if (o_free) begin
						o_status_q <= ST_OK;
						o_elem_q <= rdata_q;
						o_idx_q <= IDX_W'(rd_q);
						o_len_q <= LEN_W'(occ_q);
						o_last_q <= dump_end;
						rd_q <= rd_q + AW'(1);
						state_q <= dump_end ? S_IDLE : S_DRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid = o_valid_q;
	assign rsp.status = o_status_q;
	assign rsp.element = o_elem_q;
	assign rsp.element_index = o_idx_q;
	assign rsp.length = o_len_q;
	assign rsp.last = o_last_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(CAPACITY))
		else $error("occupancy above capacity");

	a_occ_step: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == $past(occ_q) || occ_q == $past(occ_q) + CW'(1)
		|| occ_q == $past(occ_q) - CW'(1))
		else $error("occupancy moved by more than one");

	a_busy_after_acc: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> state_q != S_IDLE)
		else $error("item accepted without work");

	a_nonlast_is_dump: assert property (@(posedge clk) disable iff (!arst_n)
		(o_valid_q && !o_last_q) |-> o_status_q == ST_OK)
		else $error("non-final result outside a dump");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import pol_pkg::*;

	localparam logic [ACT_W-1:0] ACT_SPARE = 3'd7;
	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 80;
	localparam int RANDOM_ITEMS = 245;

	typedef struct {
		logic [ACT_W-1:0] action;
		logic signed [VAL_W-1:0] value;
		logic signed [POS_W-1:0] position;
		bit hold;
		int max_gap;
	} list_cmd_t;

	typedef struct {
		logic [ST_W-1:0] status;
		logic signed [VAL_W-1:0] element;
		logic [IDX_W-1:0] element_index;
		logic [LEN_W-1:0] length;
		logic last;
	} list_rsp_t;

	logic clk;
	logic arst_n;

	pol_req_if req_if();
	pol_rsp_if rsp_if();

	positional_ordered_list u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	list_cmd_t pending[$];
	list_rsp_t expected_rsp[$];
	logic signed [VAL_W-1:0] shadow_words[CAPACITY];
	int shadow_len;
	int peak_len;
	int full_hits;
	int errors;
	int n_cmds;
	int n_rsps;
	int idle_cycles;

	list_cmd_t cur_cmd;
	bit busy;
	int gap_left;
	int stall_left;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	function automatic void expect_rsp(logic [ST_W-1:0] status, logic signed [VAL_W-1:0] elem,
		int idx, bit last);
		list_rsp_t r;
		r.status = status;
		r.element = elem;
		r.element_index = idx[IDX_W-1:0];
		r.length = shadow_len[LEN_W-1:0];
		r.last = last;
		expected_rsp.push_back(r);
	endfunction

	function automatic void place_word(int idx, logic signed [VAL_W-1:0] word);
		for (int i = shadow_len; i > idx; i--)
			shadow_words[i] = shadow_words[i-1];
		shadow_words[idx] = word;
		shadow_len++;
		if (shadow_len > peak_len)
			peak_len = shadow_len;
	endfunction

	function automatic void drop_word(int idx);
		for (int i = idx; i + 1 < shadow_len; i++)
			shadow_words[i] = shadow_words[i+1];
		shadow_len--;
	endfunction

	function automatic void apply_list_cmd(list_cmd_t c);
		int p;
		logic [ST_W-1:0] st;
		p = c.position;
		st = ST_OK;
		case (c.action)
			ACT_APPEND: begin
				if (shadow_len >= CAPACITY) st = ST_FULL;
				else place_word(shadow_len, c.value);
			end
			ACT_PREPEND: begin
				if (shadow_len >= CAPACITY) st = ST_FULL;
				else place_word(0, c.value);
			end
			ACT_INSERT: begin
				if (p < 0) st = ST_INVALID;
				else if (shadow_len >= CAPACITY) st = ST_FULL;
				else if (shadow_len == 0 || p <= 1) place_word(0, c.value);
				else if (p > shadow_len + 1) st = ST_BOUNDS;
				else place_word(p - 1, c.value);
			end
			ACT_DEL_LAST: begin
				if (shadow_len == 0) st = ST_EMPTY;
				else drop_word(shadow_len - 1);
			end
			ACT_DEL_FIRST: begin
				if (shadow_len == 0) st = ST_EMPTY;
				else drop_word(0);
			end
			ACT_DEL_POS: begin
				if (shadow_len == 0) st = ST_EMPTY;
				else if (p < 0) st = ST_INVALID;
				else if (p <= 1) drop_word(0);
				else if (p > shadow_len) st = ST_BOUNDS;
				else drop_word(p - 1);
			end
			ACT_DUMP: begin
				if (shadow_len == 0) begin
					expect_rsp(ST_EMPTY, '0, 0, 1'b1);
				end else begin
					for (int i = 0; i < shadow_len; i++)
						expect_rsp(ST_OK, shadow_words[i], i, i + 1 == shadow_len);
				end
				return;
			end
			default: ;
		endcase
		if (st == ST_FULL)
			full_hits++;
		expect_rsp(st, '0, 0, 1'b1);
	endfunction

	task automatic push_cmd(logic [ACT_W-1:0] action, logic signed [VAL_W-1:0] value,
		logic signed [POS_W-1:0] position, bit hold, int max_gap);
		list_cmd_t c;
		c.action = action;
		c.value = value;
		c.position = position;
		c.hold = hold;
		c.max_gap = max_gap;
		pending.push_back(c);
	endtask

	function automatic logic signed [VAL_W-1:0] rand_word();
		case ($urandom_range(0, 19))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [POS_W-1:0] rand_position();
		int r;
		r = $urandom_range(0, 9);
		if (r < 8) return POS_W'($urandom_range(0, CAPACITY + 2));
		if (r == 8) return POS_W'($urandom_range(32768, 65535));
		return POS_W'($urandom_range(0, 65535));
	endfunction

	// grow: mostly inserts, shrink: mostly deletes, mixed: anything
	function automatic logic [ACT_W-1:0] rand_action(int mode);
		int r;
		r = $urandom_range(0, 99);
		if (r < 3) return ACT_SPARE;
		if (r < 13) return ACT_DUMP;
		case (mode)
			0: begin
				if (r < 80) return logic'($urandom_range(0, 2)) ? ACT_INSERT : ACT_APPEND;
				if (r < 90) return ACT_PREPEND;
				return ACT_DEL_POS;
			end
			1: begin
				if (r < 40) return ACT_DEL_POS;
				if (r < 60) return ACT_DEL_LAST;
				if (r < 80) return ACT_DEL_FIRST;
				return ACT_APPEND;
			end
			default: return ACT_W'($urandom_range(0, 5));
		endcase
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			req_if.action <= ACT_APPEND;
			req_if.value <= '0;
			req_if.position <= '0;
			busy = 1'b0;
			gap_left = 0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				apply_list_cmd(cur_cmd);
				n_cmds++;
				busy = 1'b0;
				gap_left = pending.size() > 0 ? $urandom_range(0, pending[0].max_gap) : 0;
			end
			if (!busy) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending.size() > 0 && !(pending[0].hold && expected_rsp.size() > 0)) begin
					cur_cmd = pending.pop_front();
					busy = 1'b1;
					req_if.action <= cur_cmd.action;
					req_if.value <= cur_cmd.value;
					req_if.position <= cur_cmd.position;
				end
			end
			req_if.valid <= busy;
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		list_rsp_t exp_r;
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				n_rsps++;
				if (expected_rsp.size() == 0) begin
					errors++;
					$display("%0t: unexpected item status=%0d element=%0d index=%0d length=%0d last=%0b",
						$time, rsp_if.status, rsp_if.element, rsp_if.element_index,
						rsp_if.length, rsp_if.last);
				end else begin
					exp_r = expected_rsp.pop_front();
					if (rsp_if.status !== exp_r.status || rsp_if.element !== exp_r.element ||
						rsp_if.element_index !== exp_r.element_index ||
						rsp_if.length !== exp_r.length || rsp_if.last !== exp_r.last) begin
						errors++;
						$display("%0t: mismatch expected status=%0d element=%0d index=%0d length=%0d last=%0b",
							$time, exp_r.status, exp_r.element, exp_r.element_index,
							exp_r.length, exp_r.last);
						$display("%0t:          actual   status=%0d element=%0d index=%0d length=%0d last=%0b",
							$time, rsp_if.status, rsp_if.element, rsp_if.element_index,
							rsp_if.length, rsp_if.last);
					end
				end
				stall_left = ((n_rsps / 40) % 3 == 2) ? 0 : $urandom_range(0, 10);
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles = 0;
		end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		int mode;
		int span;
		int gap;
		int made;
		shadow_len = 0;
		peak_len = 0;
		full_hits = 0;
		errors = 0;
		n_cmds = 0;
		n_rsps = 0;

		push_cmd(ACT_DUMP, '0, '0, 1'b0, 10);
		push_cmd(ACT_DEL_LAST, '0, '0, 1'b0, 10);
		push_cmd(ACT_DEL_FIRST, '0, '0, 1'b0, 10);
		push_cmd(ACT_DEL_POS, '0, -16'sd1, 1'b0, 10);
		push_cmd(ACT_INSERT, 32'sd5, -16'sd32768, 1'b0, 10);
		push_cmd(ACT_INSERT, 32'sd6, 16'sd32767, 1'b0, 0);
		push_cmd(ACT_APPEND, 32'sh7fffffff, '0, 1'b0, 0);
		push_cmd(ACT_PREPEND, 32'sh80000000, '0, 1'b0, 0);
		push_cmd(ACT_INSERT, 32'sd1, 16'sd0, 1'b0, 0);
		push_cmd(ACT_INSERT, 32'sd2, 16'sd1, 1'b0, 10);
		push_cmd(ACT_INSERT, -32'sd3, 16'sd2, 1'b0, 10);
		push_cmd(ACT_INSERT, 32'sd4, 16'sd7, 1'b0, 10);
		push_cmd(ACT_INSERT, 32'sd9, 16'sd9, 1'b0, 10);
		push_cmd(ACT_DEL_POS, '0, -16'sd32768, 1'b0, 10);
		push_cmd(ACT_DEL_POS, '0, 16'sd0, 1'b0, 10);
		push_cmd(ACT_DEL_POS, '0, 16'sd1, 1'b0, 0);
		push_cmd(ACT_DEL_POS, '0, 16'sd5, 1'b0, 0);
		push_cmd(ACT_DEL_POS, '0, 16'sd5, 1'b0, 0);
		push_cmd(ACT_SPARE, '1, '1, 1'b0, 10);
		push_cmd(ACT_DUMP, '0, '0, 1'b1, 10);
		push_cmd(ACT_DEL_LAST, '0, '0, 1'b0, 10);
		push_cmd(ACT_DEL_FIRST, '0, '0, 1'b0, 10);
		push_cmd(ACT_DEL_POS, '0, 16'sd2, 1'b0, 10);
		push_cmd(ACT_DEL_POS, '0, 16'sd1, 1'b0, 10);
		push_cmd(ACT_DUMP, '0, '0, 1'b0, 10);

		made = 0;
		while (made < RANDOM_ITEMS) begin
			mode = $urandom_range(0, 2);
			span = (mode == 0) ? $urandom_range(20, 35) : $urandom_range(8, 25);
			gap = ($urandom_range(0, 3) == 0) ? 0 : 10;
			for (int i = 0; i < span && made < RANDOM_ITEMS; i++) begin
				push_cmd(rand_action(mode), rand_word(), rand_position(),
					i == 0 && $urandom_range(0, 2) == 0, gap);
				made++;
			end
		end

		@(posedge arst_n);
		while (pending.size() > 0 || busy)
			@(posedge clk);
		while (expected_rsp.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d items and checked %0d results", n_cmds, n_rsps);
		$display("longest list %0d of %0d words, full reported %0d times", peak_len, CAPACITY,
			full_hits);
		if (errors == 0 && expected_rsp.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

[files.f]
sv/pol_pkg.sv
sv/pol_if.sv
sv/positional_ordered_list.sv
test/tb_top.sv
